// ----- sv/srm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants of the rectification map block
// Field widths, extent reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package srm_pkg;
	localparam int DIM_BITS = 12;
	localparam int COEF_W = 18;
	localparam int ROW_W = 3 * COEF_W;
	localparam int FOCAL_W = 20;
	localparam int SIZE_W = 26;
	localparam int SIZE_FIELD_W = 13;
	localparam int OUT_W = 25;
	localparam int CFG_IDX_W = 3;
	// Centered pixel coordinate in Q.8.
	localparam int PIX_W = DIM_BITS + 10;
	// Products of Q2.16 by Q14.8 and sums of three of them.
	localparam int DOT_W = 48;
	// Magnitude times focal.
	localparam int NUM_W = 68;
	localparam int QUO_W = 26;
	// The numerator is formed from two half-width partial products.
	localparam int HALF_W = DOT_W / 2;
	localparam int PART_W = HALF_W + FOCAL_W;
	localparam logic signed [OUT_W-1:0] EXTENT_INIT = 25'sd2560000;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sd16777215;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -25'sd16777216;

	localparam logic [CFG_IDX_W-1:0] REG_L0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_L1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_L2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_R1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_R2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_DIV_LOAD,
		ST_DIV_MUL,
		ST_DIV_RUN,
		ST_DIV_DONE,
		ST_OUT_MAP,
		ST_OUT_OFS
	} state_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DOT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

// ----- sv/srm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srm_div: restoring unsigned divider
// Produces one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module srm_div
	import srm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DOT_W:0] rem_q;
	logic [DOT_W-1:0] den_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DOT_W:0] trial;
	logic [DOT_W:0] diff;

	assign trial = {rem_q[DOT_W-1:0], num_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!diff[DOT_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule
`default_nettype wire

// ----- sv/stereo_rectification_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_rectification_map: stereo rectification map generator
// Maps destination pixels through the left and right inverse matrices.
// ----------------------------------------------------------------------------
// Six dot products go through one shared multiplier, three products each, then
// four divisions run in turn: a load state and a multiply state form the
// numerator on a 24 by 20 multiplier, a bit-serial divider produces the 68
// quotient bits, and a done state stores the result. The divisions set the
// rate. A side whose depth is not positive skips its two divisions, which
// then pass only through the load and done states. The mapped beat is offered
// once the four divisions are through; on a frame-end pixel a second beat
// with the centering offsets follows, and the input is ready again the cycle
// after the last beat is taken. A new pixel beat is taken only in the idle
// state. Configuration is written while the block is idle.
module stereo_rectification_map
	import srm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [ROW_W-1:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: col [11:0], row_index [23:12]
	input wire logic [23:0] s_tdata,
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: left_x [24:0], left_y [49:25], right_x [74:50], right_y [99:75],
	// bad_depth [100], zero fill above
	output logic [103:0] m_tdata,
	// tuser: kind
	output logic m_tuser,
	output logic m_tlast
);
	logic [ROW_W-1:0] rows_q [6];
	logic [FOCAL_W-1:0] focal_q;
	logic [SIZE_W-1:0] size_q;

	state_t state_q, state_d;
	logic [2:0] prod_q; // product within a dot
	logic [2:0] dot_q; // 0..5: lx ly lz rx ry rz
	logic [1:0] div_q; // 0 lx,1 ly,2 rx,3 ry
	logic signed [DOT_W-1:0] acc_q;
	logic signed [DOT_W-1:0] dots_q [6];
	logic signed [DIM_BITS+9:0] rx_q, ry_q;
	logic end_q;
	logic bad_q;
	logic [PART_W-1:0] part_lo_q;
	logic signed [OUT_W-1:0] res_q [4];
	logic signed [OUT_W-1:0] xmax_q [4];
	logic signed [OUT_W-1:0] xmin_q [4];

	div_req_t dreq;
	div_rsp_t drsp;
	srm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW_W'(64'h1_0000) << (2 * COEF_W);
			rows_q[1] <= ROW_W'(64'h1_0000) << COEF_W;
			rows_q[2] <= ROW_W'(64'h1_0000);
			rows_q[3] <= ROW_W'(64'h1_0000) << (2 * COEF_W);
			rows_q[4] <= ROW_W'(64'h1_0000) << COEF_W;
			rows_q[5] <= ROW_W'(64'h1_0000);
			focal_q <= FOCAL_W'(256);
			size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_L0, REG_L1, REG_L2, REG_R0, REG_R1, REG_R2:
					rows_q[cfg_index] <= cfg_data;
				REG_FOCAL: focal_q <= cfg_data[FOCAL_W-1:0];
				REG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operands.
	logic [ROW_W-1:0] cur_row;
	logic signed [COEF_W-1:0] coef;
	logic signed [DIM_BITS+9:0] opnd;
	logic signed [DOT_W-1:0] prod;
	always_comb begin
		cur_row = rows_q[dot_q];
		case (prod_q[1:0])
			2'd0: begin
				coef = cur_row[53:36];
				opnd = rx_q;
			end
			2'd1: begin
				coef = cur_row[35:18];
				opnd = ry_q;
			end
			default: begin
				coef = cur_row[17:0];
				opnd = $signed({2'b00, focal_q});
			end
		endcase
	end
	assign prod = DOT_W'(coef) * DOT_W'(opnd);

	// Divider operand selection. The low half of the magnitude is multiplied
	// by focal first, the high half in the next cycle.
	logic signed [DOT_W-1:0] m_sel, z_sel;
	logic [DOT_W-1:0] mag;
	logic [HALF_W-1:0] mul_a;
	logic [PART_W-1:0] part;
	logic [NUM_W-1:0] num_full;
	always_comb begin
		m_sel = dots_q[{1'b0, div_q[1], 1'b0} + {2'b00, div_q[1]} + {2'b00, div_q[0]}];
		z_sel = div_q[1] ? dots_q[5] : dots_q[2];
		mag = m_sel[DOT_W-1] ? DOT_W'(-m_sel) : DOT_W'(m_sel);
		mul_a = (state_q == ST_DIV_MUL) ? mag[DOT_W-1:HALF_W] : mag[HALF_W-1:0];
		part = PART_W'(mul_a) * PART_W'(focal_q);
		num_full = {part, HALF_W'(0)} + NUM_W'(part_lo_q) + NUM_W'(z_sel[DOT_W-1:1]);
	end

	logic signed [OUT_W-1:0] sres;
	logic sbad;
	always_comb begin
		sbad = 1'b0;
		sres = '0;
		if (z_sel <= 0) begin
			sbad = 1'b1;
			sres = m_sel > 0 ? OUT_MAX : (m_sel < 0 ? OUT_MIN : '0);
		end else if (!m_sel[DOT_W-1]) begin
			if (drsp.quo > NUM_W'(24'hFF_FFFF)) begin
				sbad = 1'b1;
				sres = OUT_MAX;
			end else sres = OUT_W'(drsp.quo);
		end else begin
			if (drsp.quo > NUM_W'(25'h100_0000)) begin
				sbad = 1'b1;
				sres = OUT_MIN;
			end else sres = OUT_W'(-drsp.quo);
		end
	end

	always_comb begin
		state_d = state_q;
		dreq.start = 1'b0;
		dreq.num = num_full;
		dreq.den = z_sel;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DOT;
			ST_DOT: if (dot_q == 3'd5 && prod_q == 3'd2) state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: begin
				if (z_sel <= 0) state_d = ST_DIV_DONE;
				else state_d = ST_DIV_MUL;
			end
			ST_DIV_MUL: begin
				dreq.start = 1'b1;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: if (drsp.done) state_d = ST_DIV_DONE;
			ST_DIV_DONE: state_d = (div_q == 2'd3) ? ST_OUT_MAP : ST_DIV_LOAD;
			ST_OUT_MAP: if (m_tready) state_d = end_q ? ST_OUT_OFS : ST_IDLE;
			ST_OUT_OFS: if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_q <= '0;
			dot_q <= '0;
			div_q <= '0;
			for (int i = 0; i < 4; i++) begin
				xmax_q[i] <= -EXTENT_INIT;
				xmin_q[i] <= EXTENT_INIT;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					prod_q <= '0;
					dot_q <= '0;
					div_q <= '0;
				end
				ST_DOT: begin
					if (prod_q == 3'd2) begin
						prod_q <= '0;
						dot_q <= dot_q + 3'd1;
					end else prod_q <= prod_q + 3'd1;
				end
				ST_DIV_DONE: begin
					div_q <= div_q + 2'd1;
					if (sres > xmax_q[div_q]) xmax_q[div_q] <= sres;
					if (sres < xmin_q[div_q]) xmin_q[div_q] <= sres;
				end
				ST_OUT_OFS: if (m_tready) begin
					for (int i = 0; i < 4; i++) begin
						xmax_q[i] <= -EXTENT_INIT;
						xmin_q[i] <= EXTENT_INIT;
					end
				end
				default: ;
			endcase
		end
	end

	logic [SIZE_FIELD_W-2:0] xoff, yoff;
	assign xoff = size_q[SIZE_W-1:SIZE_FIELD_W+1];
	assign yoff = size_q[SIZE_FIELD_W-1:1];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rx_q <= PIX_W'(($signed({2'b00, s_tdata[11:0]})
					- $signed({2'b00, xoff})) * 256);
				ry_q <= PIX_W'(($signed({2'b00, s_tdata[23:12]})
					- $signed({2'b00, yoff})) * 256);
				end_q <= s_tlast;
				bad_q <= 1'b0;
				acc_q <= '0;
			end
			ST_DOT: begin
				if (prod_q == 3'd2) begin
					dots_q[dot_q] <= acc_q + prod;
					acc_q <= '0;
				end else acc_q <= acc_q + prod;
			end
			ST_DIV_LOAD: part_lo_q <= part;
			ST_DIV_DONE: begin
				res_q[div_q] <= sres;
				if (sbad) bad_q <= 1'b1;
			end
			default: ;
		endcase
	end

	logic signed [OUT_W:0] ofs [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ofs[i] = ({xmax_q[i][OUT_W-1], xmax_q[i]} - {xmin_q[i][OUT_W-1], xmin_q[i]});
			ofs[i] = (ofs[i] + (ofs[i][OUT_W] ? 26'sd1 : 26'sd0)) >>> 1;
		end
	end

	assign m_tvalid = (state_q == ST_OUT_MAP) || (state_q == ST_OUT_OFS);
	assign m_tuser = (state_q == ST_OUT_OFS);
	assign m_tlast = (state_q == ST_OUT_OFS) || !end_q;
	always_comb begin
		if (state_q == ST_OUT_OFS)
			m_tdata = {3'b000, 1'b0, ofs[3][OUT_W-1:0], ofs[2][OUT_W-1:0],
				ofs[1][OUT_W-1:0], ofs[0][OUT_W-1:0]};
		else
			m_tdata = {3'b000, bad_q, res_q[3], res_q[2], res_q[1], res_q[0]};
	end
endmodule
`default_nettype wire
